FILE: sv/qnps_pkg.sv
// shared types and constants for the quadrant nearest point search
package qnps_pkg;

	localparam int MAX_POINTS = 1024;
	localparam int COORD_BITS = 24;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int CFG_W      = 11;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int DIST_W     = SQ_W + 1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                         cmd;
		logic [IDX_W-1:0]             entry_index;
		logic signed [COORD_BITS-1:0] x_value;
		logic signed [COORD_BITS-1:0] y_value;
		logic                         dir_x_negative;
		logic                         dir_y_negative;
	} qnps_in_t;

	typedef struct packed {
		logic                         found;
		logic signed [COORD_BITS-1:0] nearest_x;
		logic signed [COORD_BITS-1:0] nearest_y;
		logic [IDX_W-1:0]             nearest_index;
	} qnps_out_t;

	typedef struct packed {
		logic load_en;
		logic start;
		logic issue;
		logic finish;
	} qnps_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic pipe_busy;
	} qnps_sts_t;

endpackage

FILE: sv/quadrant_nearest_point_search.sv
// quadrant nearest point search: a load writes one table entry, a query scans the table
// a query reads fiber_count table entries (capped at 1024), then passes read, difference,
// magnitude, square, compare and hand-off; at count 0 it reads nothing and goes to hand-off
// a new query or load is stalled until the current query has handed off its result
// loads are accepted while a previous result still waits on the output
// reset: asynchronous, clears control and fiber_count; table contents stay undefined
module quadrant_nearest_point_search
	import qnps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  qnps_in_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output qnps_out_t        out_data,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data
);

	qnps_cmd_t cmd;
	qnps_sts_t sts;

	qnps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_cmd    (in_data.cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	qnps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.out_data    (out_data),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

FILE: sv/qnps_ctrl.sv
// controller state machine: sequences loads, the table scan and the result hand-off
module qnps_ctrl
	import qnps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_cmd,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output qnps_cmd_t cmd,
	input  qnps_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.load_en = (state_q == ST_IDLE) && in_valid && (in_cmd == CMD_LOAD);
		cmd.start   = (state_q == ST_IDLE) && in_valid && (in_cmd == CMD_QUERY);
		cmd.issue   = (state_q == ST_SCAN);
		cmd.finish  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= sts.count_zero ? ST_DRAIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!sts.pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// a result is only produced once the distance pipeline has emptied
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.pipe_busy)
		else $error("result taken while pipeline still busy");

	// after an idle cycle the distance pipeline is empty unless a scan has begun
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> !sts.pipe_busy || (state_q == ST_SCAN))
		else $error("pipeline active without a scan");

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.finish)
		else $error("pending result overwritten");

endmodule

FILE: sv/qnps_dp.sv
// datapath: point table, scan address, distance pipeline, best tracker, result register
module qnps_dp
	import qnps_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	input  qnps_in_t         in_data,
	output qnps_out_t        out_data,
	input  qnps_cmd_t        cmd,
	output qnps_sts_t        sts
);

	logic signed [COORD_BITS-1:0] x_mem [MAX_POINTS];
	logic signed [COORD_BITS-1:0] y_mem [MAX_POINTS];

	logic [CFG_W-1:0]             fiber_count_q;
	logic [CNT_W-1:0]             count_sat;
	logic [CNT_W-1:0]             cnt_end_q;
	logic [CNT_W-1:0]             rd_addr_q;
	logic signed [COORD_BITS-1:0] qx_q;
	logic signed [COORD_BITS-1:0] qy_q;
	logic                         xneg_q;
	logic                         yneg_q;

	logic                         v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]             idx_s1, idx_s2, idx_s3, idx_s4;
	logic signed [COORD_BITS-1:0] x_s1, x_s2, x_s3, x_s4;
	logic signed [COORD_BITS-1:0] y_s1, y_s2, y_s3, y_s4;
	logic signed [DIFF_W-1:0]     dx_s2, dy_s2;
	logic                         ok_s3, ok_s4;
	logic [DIFF_W-1:0]            magx_s3, magy_s3;
	logic [SQ_W-1:0]              sqx_s4, sqy_s4;

	logic signed [DIFF_W-1:0]     dx, dy;
	logic                         okx, oky;
	logic [DIST_W-1:0]            sum_sq;

	logic                         have_q;
	logic [DIST_W-1:0]            best_dist_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic signed [COORD_BITS-1:0] best_x_q;
	logic signed [COORD_BITS-1:0] best_y_q;
	qnps_out_t                    out_q;

	assign count_sat = (fiber_count_q > CFG_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
	                                                         : CNT_W'(fiber_count_q);

	always_comb begin
		sts.count_zero = (count_sat == '0);
		sts.scan_last  = cmd.issue && ((rd_addr_q + CNT_W'(1)) == cnt_end_q);
		sts.pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4;
	end

	// table write on load, registered read during the scan
	always_ff @(posedge clk) begin
		if (cmd.load_en) begin
			x_mem[in_data.entry_index] <= in_data.x_value;
			y_mem[in_data.entry_index] <= in_data.y_value;
		end
		if (cmd.issue) begin
			x_s1 <= x_mem[rd_addr_q[IDX_W-1:0]];
			y_s1 <= y_mem[rd_addr_q[IDX_W-1:0]];
		end
	end

	always_comb begin
		dx  = {x_s1[COORD_BITS-1], x_s1} - {qx_q[COORD_BITS-1], qx_q};
		dy  = {y_s1[COORD_BITS-1], y_s1} - {qy_q[COORD_BITS-1], qy_q};
		// zero difference never qualifies on either side
		okx = xneg_q ? dx[DIFF_W-1] : (!dx[DIFF_W-1] && (dx != '0));
		oky = yneg_q ? dy[DIFF_W-1] : (!dy[DIFF_W-1] && (dy != '0));
		sum_sq = DIST_W'(sqx_s4) + DIST_W'(sqy_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiber_count_q <= '0;
			rd_addr_q     <= '0;
			cnt_end_q     <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
			v_s4          <= 1'b0;
			have_q        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fiber_count_q <= cfg_wr_data;
			end
			if (cmd.start) begin
				rd_addr_q <= '0;
				cnt_end_q <= count_sat;
			end else if (cmd.issue) begin
				rd_addr_q <= rd_addr_q + CNT_W'(1);
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.start) begin
				have_q <= 1'b0;
			end else if (v_s4 && ok_s4 && (!have_q || (sum_sq < best_dist_q))) begin
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qx_q   <= in_data.x_value;
			qy_q   <= in_data.y_value;
			xneg_q <= in_data.dir_x_negative;
			yneg_q <= in_data.dir_y_negative;
		end
		idx_s1 <= rd_addr_q[IDX_W-1:0];
		// difference stage
		dx_s2  <= dx;
		dy_s2  <= dy;
		idx_s2 <= idx_s1;
		x_s2   <= x_s1;
		y_s2   <= y_s1;
		// magnitude stage; qualification needs only the sign of the difference and whether it is zero
		ok_s3   <= (xneg_q ? dx_s2[DIFF_W-1] : (!dx_s2[DIFF_W-1] && (dx_s2 != '0))) &&
		           (yneg_q ? dy_s2[DIFF_W-1] : (!dy_s2[DIFF_W-1] && (dy_s2 != '0)));
		magx_s3 <= dx_s2[DIFF_W-1] ? DIFF_W'(-dx_s2) : DIFF_W'(dx_s2);
		magy_s3 <= dy_s2[DIFF_W-1] ? DIFF_W'(-dy_s2) : DIFF_W'(dy_s2);
		idx_s3  <= idx_s2;
		x_s3    <= x_s2;
		y_s3    <= y_s2;
		// square stage
		sqx_s4 <= SQ_W'(magx_s3) * SQ_W'(magx_s3);
		sqy_s4 <= SQ_W'(magy_s3) * SQ_W'(magy_s3);
		ok_s4  <= ok_s3;
		idx_s4 <= idx_s3;
		x_s4   <= x_s3;
		y_s4   <= y_s3;
		// strict compare keeps the earliest entry on a tie
		if (v_s4 && ok_s4 && (!have_q || (sum_sq < best_dist_q))) begin
			best_dist_q <= sum_sq;
			best_idx_q  <= idx_s4;
			best_x_q    <= x_s4;
			best_y_q    <= y_s4;
		end
		if (cmd.finish) begin
			out_q.found         <= have_q;
			out_q.nearest_x     <= have_q ? best_x_q : '0;
			out_q.nearest_y     <= have_q ? best_y_q : '0;
			out_q.nearest_index <= have_q ? best_idx_q : '0;
		end
	end

	assign out_data = out_q;

	// the scan address never runs past the searched range
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (rd_addr_q < cnt_end_q))
		else $error("scan address beyond entry count");

	// a query starts only with an empty pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !sts.pipe_busy)
		else $error("query started while pipeline busy");

	// the best entry only appears from a qualifying pipeline slot
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(have_q) |-> $past(v_s4 && ok_s4))
		else $error("best entry set without a qualifying point");

	// the okx/oky pre-check and the registered check agree
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ##2 (ok_s3 == $past(okx && oky, 2)))
		else $error("qualification mismatch between stages");

endmodule
